### hw/rtl/pdb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdb_pkg
// Shared types and codes of the per-endpoint dispatch batcher.
// ----------------------------------------------------------------------------
package pdb_pkg;

  localparam int TOKEN_W   = 64;
  localparam int EP_W      = 6;
  localparam int LIMIT_W   = 7;
  localparam int CORES_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;
  localparam int TICKET_W  = TOKEN_W + EP_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FABRIC_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBSERVE_ONLY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INGRESS_ENABLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORE_COUNT     = 2'd3;

  localparam logic [CORES_W-1:0] CORE_COUNT_RESET = 7'd16;

  typedef enum logic {
    MODE_ENQUEUE = 1'b0,
    MODE_COLLECT = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    KIND_ENQ_ANSWER = 2'd0,
    KIND_DISPATCH   = 2'd1,
    KIND_EMPTY      = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic enq;        // enqueue transaction accepted this cycle
    logic col_start;  // collect transaction accepted this cycle
    logic scan;       // process the ticket at the read port
    logic finish;     // deliver the closing result of a collect
  } pdb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic col_open;   // a collect would scan at least one ticket
    logic scan_more;  // the scan goes on after the current ticket
  } pdb_stat_t;

endpackage
`default_nettype wire

### hw/rtl/pdb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### hw/rtl/pdb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdb_datapath
// Ticket ring, configuration registers, scan bookkeeping and result registers.
// ----------------------------------------------------------------------------
module pdb_datapath import pdb_pkg::*; #(
  parameter int QUEUE_DEPTH = 64,
  parameter int MAX_CORES   = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  wire logic [TOKEN_W-1:0]   ticket_token_i,
  input  wire logic [EP_W-1:0]      target_endpoint_i,
  input  wire logic [LIMIT_W-1:0]   batch_limit_i,
  input  wire pdb_cmd_t             cmd_i,
  output pdb_stat_t                 stat_o,
  output logic                      res_strobe_o,
  output result_kind_e              result_kind_o,
  output logic                      accepted_o,
  output logic      [TOKEN_W-1:0]   out_token_o,
  output logic      [EP_W-1:0]      out_endpoint_o,
  output logic                      last_o
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SEEN_W = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;

  // Configuration.
  logic               fabric_en_q, observe_q, ingress_q;
  logic [CORES_W-1:0] core_count_q;
  logic [CORES_W-1:0] cores;
  logic               path_open;

  // Ring state and scan bookkeeping.
  logic [PTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]   count_q, count_d, remain_q, remain_d;
  logic [LIMIT_W-1:0] budget_q, budget_d, emit_cnt_q, emit_cnt_d;
  logic [MAX_CORES-1:0] seen_q, seen_d;
  logic               pend_vld_q, pend_vld_d;
  logic [TOKEN_W-1:0] pend_tok_q, pend_tok_d;
  logic [EP_W-1:0]    pend_ep_q, pend_ep_d;

  // Result registers.
  logic               strobe_q, strobe_d;
  result_kind_e       kind_q, kind_d;
  logic               acc_q, acc_d, last_q, last_d;
  logic [TOKEN_W-1:0] tok_q, tok_d;
  logic [EP_W-1:0]    ep_q, ep_d;

  // Memory port signals.
  logic                ram_we;
  logic [TICKET_W-1:0] ram_wdata, ram_rdata;
  logic [TOKEN_W-1:0]  t_tok;
  logic [EP_W-1:0]     t_ep;

  logic enq_ok, stale, hit, emit, rotate;
  logic [LIMIT_W-1:0] n_new;
  logic [CNT_W-1:0]   remain_new;

  always_comb begin
    if (core_count_q == '0) begin
      cores = CORES_W'(1);
    end else if (core_count_q > CORES_W'(MAX_CORES)) begin
      cores = CORES_W'(MAX_CORES);
    end else begin
      cores = core_count_q;
    end
  end

  assign path_open = fabric_en_q && !observe_q && ingress_q;

  assign enq_ok = path_open && (ticket_token_i != '0) &&
                  ({1'b0, target_endpoint_i} < cores) &&
                  (count_q != CNT_W'(QUEUE_DEPTH));

  assign {t_ep, t_tok} = ram_rdata;

  // A ticket whose endpoint is no longer a valid core bypasses the seen check.
  assign stale      = ({1'b0, t_ep} >= cores);
  assign hit        = !stale && seen_q[t_ep[SEEN_W-1:0]];
  assign rotate     = hit;
  assign emit       = !hit;
  assign n_new      = emit_cnt_q + LIMIT_W'(emit);
  assign remain_new = remain_q - 1'b1;

  assign stat_o.col_open  = path_open && (batch_limit_i != '0) && (count_q != '0);
  assign stat_o.scan_more = (remain_new != '0) && (n_new < budget_q);

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    remain_d   = remain_q;
    budget_d   = budget_q;
    emit_cnt_d = emit_cnt_q;
    seen_d     = seen_q;
    pend_vld_d = pend_vld_q;
    pend_tok_d = pend_tok_q;
    pend_ep_d  = pend_ep_q;
    strobe_d   = 1'b0;
    kind_d     = KIND_ENQ_ANSWER;
    acc_d      = 1'b0;
    tok_d      = '0;
    ep_d       = '0;
    last_d     = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = ram_rdata;

    if (cmd_i.enq) begin
      strobe_d = 1'b1;
      acc_d    = enq_ok;
      last_d   = 1'b1;
      if (enq_ok) begin
        ram_we    = 1'b1;
        ram_wdata = {target_endpoint_i, ticket_token_i};
        tail_d    = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
        count_d   = count_q + 1'b1;
      end
    end

    if (cmd_i.col_start) begin
      seen_d     = '0;
      emit_cnt_d = '0;
      remain_d   = count_q;
      budget_d   = (batch_limit_i < cores) ? batch_limit_i : cores;
      pend_vld_d = 1'b0;
    end

    if (cmd_i.scan) begin
      head_d     = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
      remain_d   = remain_new;
      emit_cnt_d = n_new;
      count_d    = count_q - 1'b1 + CNT_W'(rotate);
      if (rotate) begin
        ram_we = 1'b1;
        tail_d = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
      end
      if (emit) begin
        if (!stale) begin
          seen_d[t_ep[SEEN_W-1:0]] = 1'b1;
        end
        // One emitted ticket is held back so that the final one can carry last.
        if (pend_vld_q) begin
          strobe_d = 1'b1;
          kind_d   = KIND_DISPATCH;
          tok_d    = pend_tok_q;
          ep_d     = pend_ep_q;
        end
        pend_vld_d = 1'b1;
        pend_tok_d = t_tok;
        pend_ep_d  = t_ep;
      end
    end

    if (cmd_i.finish) begin
      strobe_d   = 1'b1;
      last_d     = 1'b1;
      pend_vld_d = 1'b0;
      if (pend_vld_q) begin
        kind_d = KIND_DISPATCH;
        tok_d  = pend_tok_q;
        ep_d   = pend_ep_q;
      end else begin
        kind_d = KIND_EMPTY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fabric_en_q  <= 1'b1;
      observe_q    <= 1'b0;
      ingress_q    <= 1'b1;
      core_count_q <= CORE_COUNT_RESET;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      remain_q     <= '0;
      budget_q     <= '0;
      emit_cnt_q   <= '0;
      seen_q       <= '0;
      pend_vld_q   <= 1'b0;
      strobe_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FABRIC_ENABLE:  fabric_en_q  <= cfg_wdata_i[0];
          REG_OBSERVE_ONLY:   observe_q    <= cfg_wdata_i[0];
          REG_INGRESS_ENABLE: ingress_q    <= cfg_wdata_i[0];
          REG_CORE_COUNT:     core_count_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      remain_q   <= remain_d;
      budget_q   <= budget_d;
      emit_cnt_q <= emit_cnt_d;
      seen_q     <= seen_d;
      pend_vld_q <= pend_vld_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_tok_q <= pend_tok_d;
    pend_ep_q  <= pend_ep_d;
    kind_q     <= kind_d;
    acc_q      <= acc_d;
    tok_q      <= tok_d;
    ep_q       <= ep_d;
    last_q     <= last_d;
  end

  // The read address follows the next head, so the ticket at the head is
  // always waiting at the read port when a scan step needs it.
  pdb_ram #(
    .WIDTH (TICKET_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ticket_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .raddr_i (head_d),
    .rdata_o (ram_rdata)
  );

  assign res_strobe_o   = strobe_q;
  assign result_kind_o  = kind_q;
  assign accepted_o     = acc_q;
  assign out_token_o    = tok_q;
  assign out_endpoint_o = ep_q;
  assign last_o         = last_q;

endmodule
`default_nettype wire

### hw/rtl/pdb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdb_ctrl
// Sequencer of the dispatch batcher: accepts transactions and steps a scan.
// ----------------------------------------------------------------------------
module pdb_ctrl import pdb_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire logic      mode_i,
  input  wire pdb_stat_t stat_i,
  output logic           busy,
  output pdb_cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (mode_i == MODE_COLLECT)) begin
          state_d = stat_i.col_open ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (!stat_i.scan_more) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy            = (state_q != ST_IDLE);
    cmd_o.enq       = accept && (mode_i == MODE_ENQUEUE);
    cmd_o.col_start = accept && (mode_i == MODE_COLLECT);
    cmd_o.scan      = (state_q == ST_SCAN);
    cmd_o.finish    = (state_q == ST_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/per_endpoint_dispatch_batcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// per_endpoint_dispatch_batcher
// FIFO of dispatch tickets; a collect emits at most one ticket per valid endpoint.
//
//   Channel   Signals                                         Handshake
//   command   start, mode_i, ticket_token_i,                  start && !busy
//             target_endpoint_i, batch_limit_i
//   result    result_kind_o, accepted_o, out_token_o,         res_strobe_o, 1 cycle
//             out_endpoint_o, last_o
//   config    cfg_we_i, cfg_index_i, cfg_wdata_i              cfg_we_i
//
// An enqueue leaves busy low; its answer shows in the cycle after acceptance and
// enqueues may follow in every cycle. A collect keeps busy high while it scans
// at most QUEUE_DEPTH tickets and through the closing ST_DONE state; the scan
// reads one ticket per cycle from the ticket RAM read port. Results are strobed
// one at a time and cannot be stalled. Reset empties the queue and loads the
// register defaults; the ticket RAM itself is not cleared.
// ----------------------------------------------------------------------------
module per_endpoint_dispatch_batcher import pdb_pkg::*; #(
  parameter int QUEUE_DEPTH = 64,
  parameter int MAX_CORES   = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 mode_i,
  input  wire logic [TOKEN_W-1:0]   ticket_token_i,
  input  wire logic [EP_W-1:0]      target_endpoint_i,
  input  wire logic [LIMIT_W-1:0]   batch_limit_i,
  output logic                      res_strobe_o,
  output logic      [1:0]           result_kind_o,
  output logic                      accepted_o,
  output logic      [TOKEN_W-1:0]   out_token_o,
  output logic      [EP_W-1:0]      out_endpoint_o,
  output logic                      last_o
);

  pdb_cmd_t     cmd;
  pdb_stat_t    stat;
  result_kind_e kind;

  pdb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (mode_i),
    .stat_i (stat),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  pdb_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_CORES   (MAX_CORES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .ticket_token_i    (ticket_token_i),
    .target_endpoint_i (target_endpoint_i),
    .batch_limit_i     (batch_limit_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .res_strobe_o      (res_strobe_o),
    .result_kind_o     (kind),
    .accepted_o        (accepted_o),
    .out_token_o       (out_token_o),
    .out_endpoint_o    (out_endpoint_o),
    .last_o            (last_o)
  );

  assign result_kind_o = kind;

endmodule
`default_nettype wire

### verif/dispatch_batch_checker.sv
// ----------------------------------------------------------------------------
// dispatch_batch_checker
// Watches the command, configuration and result channels of the dispatch
// batcher. It keeps its own copy of the ticket queue and the registers,
// predicts the results of every accepted transaction and compares each
// strobed result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module dispatch_batch_checker import pdb_pkg::*; #(
  parameter int QUEUE_DEPTH = 64,
  parameter int MAX_CORES   = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic                 mode_i,
  input  logic [TOKEN_W-1:0]   ticket_token_i,
  input  logic [EP_W-1:0]      target_endpoint_i,
  input  logic [LIMIT_W-1:0]   batch_limit_i,
  input  logic                 res_strobe_i,
  input  logic [1:0]           result_kind_i,
  input  logic                 accepted_i,
  input  logic [TOKEN_W-1:0]   out_token_i,
  input  logic [EP_W-1:0]      out_endpoint_i,
  input  logic                 last_i,
  output int                   mismatch_count_o,
  output int                   pending_o
);

  typedef struct packed {
    result_kind_e       kind;
    logic               accepted;
    logic [TOKEN_W-1:0] token;
    logic [EP_W-1:0]    endpoint;
    logic               last;
  } dispatch_result_t;

  // Shadow of the ticket queue and the registers.
  logic [TOKEN_W-1:0] queued_token [QUEUE_DEPTH];
  logic [EP_W-1:0]    queued_ep    [QUEUE_DEPTH];
  int                 head;
  int                 tail;
  int                 queued;
  bit                 fabric_en;
  bit                 observe_on;
  bit                 ingress_en;
  logic [CORES_W-1:0] core_count;

  dispatch_result_t   awaited_results [$];
  int                 mismatches = 0;
  int                 pending = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending;

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  task automatic predict_dispatch(input mode_e mode, input logic [TOKEN_W-1:0] token,
                                  input logic [EP_W-1:0] ep, input logic [LIMIT_W-1:0] lim);
    int unsigned        cores;
    int unsigned        budget;
    int unsigned        scan_total;
    int unsigned        s;
    bit                 open_path;
    bit                 taken;
    bit                 seen [MAX_CORES];
    logic [TOKEN_W-1:0] t_tok;
    logic [EP_W-1:0]    t_ep;
    dispatch_result_t   batch [$];

    cores = (core_count == 0) ? 1 : ((core_count > MAX_CORES) ? MAX_CORES : core_count);
    open_path = fabric_en && !observe_on && ingress_en;
    if (mode == MODE_ENQUEUE) begin
      taken = open_path && (token != '0) && (ep < cores) && (queued < QUEUE_DEPTH);
      if (taken) begin
        queued_token[tail] = token;
        queued_ep[tail] = ep;
        tail = (tail + 1) % QUEUE_DEPTH;
        queued++;
      end
      awaited_results.insert(awaited_results.size(),
                             '{KIND_ENQ_ANSWER, taken, '0, '0, 1'b1});
    end else begin
      if (open_path && lim != 0 && queued != 0) begin
        budget = (lim < cores) ? lim : cores;
        scan_total = queued;
        foreach (seen[i]) seen[i] = 1'b0;
        for (s = 0; s < scan_total && batch.size() < budget; s++) begin
          t_tok = queued_token[head];
          t_ep = queued_ep[head];
          head = (head + 1) % QUEUE_DEPTH;
          queued--;
          // A ticket left behind by a lowered core count skips the
          // per-endpoint check but still uses up budget.
          if (t_ep >= cores || !seen[t_ep]) begin
            if (t_ep < cores) seen[t_ep] = 1'b1;
            batch.insert(batch.size(), '{KIND_DISPATCH, 1'b0, t_tok, t_ep, 1'b0});
          end else begin
            queued_token[tail] = t_tok;
            queued_ep[tail] = t_ep;
            tail = (tail + 1) % QUEUE_DEPTH;
            queued++;
          end
        end
      end
      if (batch.size() == 0) begin
        awaited_results.insert(awaited_results.size(),
                               '{KIND_EMPTY, 1'b0, '0, '0, 1'b1});
      end else begin
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) awaited_results.insert(awaited_results.size(), batch[i]);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dispatch_result_t want;
    if (!rst_ni) begin
      head = 0;
      tail = 0;
      queued = 0;
      fabric_en = 1'b1;
      observe_on = 1'b0;
      ingress_en = 1'b1;
      core_count = CORE_COUNT_RESET;
      awaited_results.delete();
      pending = 0;
    end else begin
      // A result never belongs to a transaction accepted at the same edge,
      // so results are matched before new predictions are queued.
      if (res_strobe_i) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, kind %0d token %0h endpoint %0d",
                   $time, result_kind_i, out_token_i, out_endpoint_i);
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          check_field("result_kind", 64'(want.kind), 64'(result_kind_i));
          check_field("accepted", 64'(want.accepted), 64'(accepted_i));
          check_field("out_token", want.token, out_token_i);
          check_field("out_endpoint", 64'(want.endpoint), 64'(out_endpoint_i));
          check_field("last", 64'(want.last), 64'(last_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FABRIC_ENABLE:  fabric_en = cfg_wdata_i[0];
          REG_OBSERVE_ONLY:   observe_on = cfg_wdata_i[0];
          REG_INGRESS_ENABLE: ingress_en = cfg_wdata_i[0];
          REG_CORE_COUNT:     core_count = cfg_wdata_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        predict_dispatch(mode_e'(mode_i), ticket_token_i, target_endpoint_i, batch_limit_i);
      end
      pending = awaited_results.size();
    end
  end

endmodule

### verif/per_endpoint_dispatch_batcher_tb.sv
// ----------------------------------------------------------------------------
// per_endpoint_dispatch_batcher_tb
// Drives the dispatch batcher with a short directed sequence and then with
// random enqueue and collect transactions under a range of register settings,
// some phases in bursts with random gaps. A checker beside the block predicts
// and compares every result; this module reports the verdict.
// ----------------------------------------------------------------------------
module per_endpoint_dispatch_batcher_tb;
  import pdb_pkg::*;

  localparam int QUEUE_DEPTH = 64;
  localparam int MAX_CORES   = 64;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_wdata_i;
  logic                 start;
  logic                 busy;
  logic                 mode_i;
  logic [TOKEN_W-1:0]   ticket_token_i;
  logic [EP_W-1:0]      target_endpoint_i;
  logic [LIMIT_W-1:0]   batch_limit_i;
  logic                 res_strobe_o;
  logic [1:0]           result_kind_o;
  logic                 accepted_o;
  logic [TOKEN_W-1:0]   out_token_o;
  logic [EP_W-1:0]      out_endpoint_o;
  logic                 last_o;
  int                   mismatches;
  int                   pending;
  int                   cur_cores;

  per_endpoint_dispatch_batcher #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_CORES  (MAX_CORES)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start            (start),
    .busy             (busy),
    .mode_i           (mode_i),
    .ticket_token_i   (ticket_token_i),
    .target_endpoint_i(target_endpoint_i),
    .batch_limit_i    (batch_limit_i),
    .res_strobe_o     (res_strobe_o),
    .result_kind_o    (result_kind_o),
    .accepted_o       (accepted_o),
    .out_token_o      (out_token_o),
    .out_endpoint_o   (out_endpoint_o),
    .last_o           (last_o)
  );

  dispatch_batch_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_CORES  (MAX_CORES)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start),
    .busy_i           (busy),
    .mode_i           (mode_i),
    .ticket_token_i   (ticket_token_i),
    .target_endpoint_i(target_endpoint_i),
    .batch_limit_i    (batch_limit_i),
    .res_strobe_i     (res_strobe_o),
    .result_kind_i    (result_kind_o),
    .accepted_i       (accepted_o),
    .out_token_i      (out_token_o),
    .out_endpoint_i   (out_endpoint_o),
    .last_i           (last_o),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // A watchdog ends a run that hangs and reports it as mismatches.
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Presents one transaction and returns at the edge that accepts it.
  task automatic send(input mode_e mode, input logic [TOKEN_W-1:0] token,
                      input logic [EP_W-1:0] ep, input logic [LIMIT_W-1:0] lim);
    start <= 1'b1;
    mode_i <= mode;
    ticket_token_i <= token;
    target_endpoint_i <= ep;
    batch_limit_i <= lim;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Single-bit registers get random upper data bits, which must be ignored.
  task automatic apply_settings(input bit fe, input bit oo, input bit ie,
                                input logic [CORES_W-1:0] cc);
    logic [CFG_DAT_W-2:0] pad;
    pad = (CFG_DAT_W-1)'($urandom);
    write_reg(REG_FABRIC_ENABLE, {pad, fe});
    pad = (CFG_DAT_W-1)'($urandom);
    write_reg(REG_OBSERVE_ONLY, {pad, oo});
    pad = (CFG_DAT_W-1)'($urandom);
    write_reg(REG_INGRESS_ENABLE, {pad, ie});
    write_reg(REG_CORE_COUNT, cc);
    cfg_we_i <= 1'b0;
    cur_cores = (cc == 0) ? 1 : ((cc > MAX_CORES) ? MAX_CORES : cc);
  endtask

  task automatic run_phase(input int n_items, input int enq_pct, input bit paced);
    int                 r;
    int                 gap;
    int                 burst_left;
    int                 hot;
    mode_e              mode;
    logic [TOKEN_W-1:0] token;
    logic [EP_W-1:0]    ep;
    logic [LIMIT_W-1:0] lim;

    burst_left = $urandom_range(0, 12);
    hot = (cur_cores < 4) ? cur_cores : 4;
    repeat (n_items) begin
      mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQUEUE : MODE_COLLECT;
      token = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 5) token = '0;
      else if (r < 8) token = '1;
      // A small hot set of endpoints makes collects rotate duplicates.
      r = $urandom_range(0, 99);
      if (r < 10) ep = EP_W'($urandom_range(0, 63));
      else if (r < 40) ep = EP_W'($urandom_range(0, hot - 1));
      else ep = EP_W'($urandom_range(0, cur_cores - 1));
      r = $urandom_range(0, 99);
      if (r < 8) lim = '0;
      else if (r < 18) lim = LIMIT_W'($urandom_range(0, 127));
      else lim = LIMIT_W'($urandom_range(1, cur_cores));
      send(mode, token, ep, lim);
      if (paced) begin
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          gap = $urandom_range(0, 6);
          if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
          burst_left = $urandom_range(0, 12);
        end
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_wdata_i <= '0;
    start <= 1'b0;
    mode_i <= MODE_ENQUEUE;
    ticket_token_i <= '0;
    target_endpoint_i <= '0;
    batch_limit_i <= '0;
    cur_cores = CORE_COUNT_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset settings: sixteen cores, path open.
    send(MODE_COLLECT, {$urandom, $urandom}, 6'd9, 7'd5);
    send(MODE_ENQUEUE, '0, 6'd3, 7'd127);
    send(MODE_ENQUEUE, '1, 6'd0, 7'd0);
    send(MODE_ENQUEUE, 64'd1, 6'd15, 7'd64);
    send(MODE_ENQUEUE, {$urandom, $urandom}, 6'd16, 7'd3);
    send(MODE_ENQUEUE, {$urandom, $urandom}, 6'd63, 7'd1);
    send(MODE_ENQUEUE, {$urandom, $urandom}, 6'd0, 7'd2);
    send(MODE_ENQUEUE, {$urandom, $urandom}, 6'd5, 7'd0);
    send(MODE_ENQUEUE, {$urandom, $urandom}, 6'd0, 7'd9);
    send(MODE_COLLECT, {$urandom, $urandom}, 6'd63, 7'd0);
    send(MODE_COLLECT, '1, 6'd0, 7'd127);
    send(MODE_COLLECT, '0, 6'd1, 7'd1);
    send(MODE_COLLECT, {$urandom, $urandom}, 6'd2, 7'd64);
    send(MODE_COLLECT, {$urandom, $urandom}, 6'd4, 7'd2);
    // The budget runs out before the last ticket is scanned, so that ticket
    // must stay ahead of the rotated duplicate.
    send(MODE_ENQUEUE, {$urandom, $urandom}, 6'd1, 7'd0);
    send(MODE_ENQUEUE, {$urandom, $urandom}, 6'd1, 7'd0);
    send(MODE_ENQUEUE, {$urandom, $urandom}, 6'd2, 7'd0);
    send(MODE_ENQUEUE, {$urandom, $urandom}, 6'd3, 7'd0);
    send(MODE_COLLECT, {$urandom, $urandom}, 6'd0, 7'd2);
    send(MODE_COLLECT, {$urandom, $urandom}, 6'd0, 7'd64);
    send(MODE_COLLECT, {$urandom, $urandom}, 6'd0, 7'd64);
    wait_idle();

    // All endpoints valid, then a lowered count leaves stale tickets behind.
    apply_settings(1'b1, 1'b0, 1'b1, 7'd64);
    run_phase(50, 80, 1'b1);
    wait_idle();
    apply_settings(1'b1, 1'b0, 1'b1, 7'd4);
    run_phase(30, 40, 1'b1);
    wait_idle();
    // One effective core drains one ticket per collect, so the queue fills.
    apply_settings(1'b1, 1'b0, 1'b1, 7'd0);
    run_phase(80, 92, 1'b0);
    wait_idle();
    apply_settings(1'b1, 1'b0, 1'b1, 7'd127);
    run_phase(35, 55, 1'b1);
    wait_idle();
    apply_settings(1'b0, 1'b0, 1'b1, 7'd64);
    run_phase(15, 50, 1'b1);
    wait_idle();
    apply_settings(1'b1, 1'b1, 1'b1, 7'd64);
    run_phase(15, 50, 1'b0);
    wait_idle();
    apply_settings(1'b1, 1'b0, 1'b0, 7'd64);
    run_phase(15, 50, 1'b1);
    wait_idle();
    apply_settings(1'b1, 1'b0, 1'b1, 7'd8);
    run_phase(50, 65, 1'b1);
    wait_idle();
    apply_settings(1'b1, 1'b0, 1'b1, 7'd65);
    run_phase(25, 70, 1'b0);
    wait_idle();
    apply_settings(1'b1, 1'b0, 1'b1, 7'd16);
    run_phase(30, 60, 1'b1);
    wait_idle();

    repeat (QUEUE_DEPTH + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
